/* design/ptzfe_pkg.sv */
// ----------------------------------------------------------------------------
// ptzfe_pkg
// Types and constants shared by the pan-tilt-zoom command frame encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptzfe_pkg;

  localparam int unsigned FrameBytes = 9;
  localparam int unsigned CmdBytes   = 5;

  localparam logic [7:0] StartByte  = 8'ha0;
  localparam logic [7:0] SpeedMax   = 8'h40;
  localparam logic [7:0] ExtCmd     = 8'h03;
  localparam logic [7:0] PresetSet  = 8'h50;
  localparam logic [7:0] PresetGoto = 8'h19;
  localparam logic [7:0] PresetClr  = 8'h51;
  localparam logic [7:0] PatternCmd = 8'h1b;
  localparam logic [7:0] AutopanCmd = 8'h1a;
  localparam logic [7:0] TourCmd    = 8'h13;
  localparam logic [7:0] MenuCmd    = 8'h17;
  localparam logic [7:0] ResetCmd   = 8'h1e;
  localparam logic [7:0] ZoomSpdCmd = 8'h80;

  typedef logic [FrameBytes-1:0][7:0] frame_t;

  typedef enum logic [4:0] {
    OP_LEFT          = 5'd0,
    OP_RIGHT         = 5'd1,
    OP_UP            = 5'd2,
    OP_DOWN          = 5'd3,
    OP_UP_LEFT       = 5'd4,
    OP_DOWN_LEFT     = 5'd5,
    OP_UP_RIGHT      = 5'd6,
    OP_DOWN_RIGHT    = 5'd7,
    OP_AUTOSCAN      = 5'd8,
    OP_NOOP          = 5'd9,
    OP_FOCUS_NEAR    = 5'd10,
    OP_FOCUS_FAR     = 5'd11,
    OP_IRIS_OPEN     = 5'd12,
    OP_IRIS_CLOSE    = 5'd13,
    OP_ZOOM_TELE     = 5'd14,
    OP_ZOOM_WIDE     = 5'd15,
    OP_PRESET_SET    = 5'd16,
    OP_PRESET_GOTO   = 5'd17,
    OP_PRESET_CLEAR  = 5'd18,
    OP_PATTERN_START = 5'd19,
    OP_PATTERN_RUN   = 5'd20,
    OP_PATTERN_STOP  = 5'd21,
    OP_AUTOPAN_START = 5'd22,
    OP_AUTOPAN_STOP  = 5'd23,
    OP_TOUR_RUN      = 5'd24,
    OP_TOUR_STOP     = 5'd25,
    OP_MENU_ON       = 5'd26,
    OP_MENU_OFF      = 5'd27,
    OP_RESET         = 5'd28,
    OP_ZOOM_SPEED    = 5'd29
  } op_t;

endpackage

`default_nettype wire

/* design/ptzfe_cmd_encode.sv */
// ----------------------------------------------------------------------------
// ptzfe_cmd_encode
// Builds the nine-byte frame of one command: start, addresses, command
// bytes from the opcode table with clamped arguments, and checksum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptzfe_cmd_encode (
  input  wire logic [4:0]      op,
  input  wire logic [7:0]      sender_address,
  input  wire logic [7:0]      target_address,
  input  wire logic [7:0]      pan_speed,
  input  wire logic [7:0]      tilt_speed,
  input  wire logic [7:0]      number,
  output ptzfe_pkg::frame_t    frame
);

  logic [7:0] ps;
  logic [7:0] ts;
  logic [7:0] pat;
  logic [7:0] n14;
  logic [7:0] pre;
  logic [7:0] c [ptzfe_pkg::CmdBytes];
  logic [7:0] sum;

  assign ps  = (pan_speed > ptzfe_pkg::SpeedMax) ? ptzfe_pkg::SpeedMax : pan_speed;
  assign ts  = (tilt_speed > ptzfe_pkg::SpeedMax) ? ptzfe_pkg::SpeedMax : tilt_speed;
  assign pat = (number == 8'd0) ? 8'd1 : ((number > 8'd3) ? 8'd3 : number);
  assign n14 = (number == 8'd0) ? 8'd1 : ((number > 8'd4) ? 8'd4 : number);
  // preset numbers are zero based on the wire, zero wraps to 0xff
  assign pre = number - 8'd1;

  always_comb begin
    c[0] = 8'h01;
    c[1] = 8'h00;
    c[2] = 8'h00;
    c[3] = 8'hff;
    c[4] = 8'hff;
    case (ptzfe_pkg::op_t'(op))
      ptzfe_pkg::OP_LEFT: begin
        c[2] = 8'h01; c[3] = ps;
      end
      ptzfe_pkg::OP_RIGHT: begin
        c[2] = 8'h02; c[3] = ps;
      end
      ptzfe_pkg::OP_UP: begin
        c[2] = 8'h04; c[4] = ps;
      end
      ptzfe_pkg::OP_DOWN: begin
        c[2] = 8'h08; c[4] = ps;
      end
      ptzfe_pkg::OP_UP_LEFT: begin
        c[2] = 8'h05; c[3] = ps; c[4] = ts;
      end
      ptzfe_pkg::OP_DOWN_LEFT: begin
        c[2] = 8'h09; c[3] = ps; c[4] = ts;
      end
      ptzfe_pkg::OP_UP_RIGHT: begin
        c[2] = 8'h06; c[3] = ps; c[4] = ts;
      end
      ptzfe_pkg::OP_DOWN_RIGHT: begin
        c[2] = 8'h0a; c[3] = ps; c[4] = ts;
      end
      ptzfe_pkg::OP_AUTOSCAN, ptzfe_pkg::OP_PATTERN_START: begin
        c[0] = 8'hff; c[1] = 8'hff; c[2] = 8'hff; c[3] = 8'hff; c[4] = 8'hff;
      end
      ptzfe_pkg::OP_FOCUS_NEAR: c[1] = 8'h02;
      ptzfe_pkg::OP_FOCUS_FAR:  c[1] = 8'h01;
      ptzfe_pkg::OP_IRIS_OPEN:  c[1] = 8'h08;
      ptzfe_pkg::OP_IRIS_CLOSE: c[1] = 8'h10;
      ptzfe_pkg::OP_ZOOM_TELE:  c[1] = 8'h20;
      ptzfe_pkg::OP_ZOOM_WIDE:  c[1] = 8'h40;
      ptzfe_pkg::OP_PRESET_SET: begin
        c[0] = ptzfe_pkg::ExtCmd; c[1] = ptzfe_pkg::PresetSet; c[2] = pre;
      end
      ptzfe_pkg::OP_PRESET_GOTO: begin
        c[0] = ptzfe_pkg::ExtCmd; c[1] = ptzfe_pkg::PresetGoto; c[2] = pre;
      end
      ptzfe_pkg::OP_PRESET_CLEAR: begin
        c[0] = ptzfe_pkg::ExtCmd; c[1] = ptzfe_pkg::PresetClr; c[2] = pre;
      end
      ptzfe_pkg::OP_PATTERN_RUN: begin
        c[0] = ptzfe_pkg::ExtCmd; c[1] = ptzfe_pkg::PatternCmd; c[2] = pat; c[3] = 8'h01;
      end
      ptzfe_pkg::OP_PATTERN_STOP: begin
        c[0] = ptzfe_pkg::ExtCmd; c[1] = ptzfe_pkg::PatternCmd; c[2] = pat; c[3] = 8'h00;
      end
      ptzfe_pkg::OP_AUTOPAN_START: begin
        c[0] = ptzfe_pkg::ExtCmd; c[1] = ptzfe_pkg::AutopanCmd; c[2] = 8'h01; c[3] = n14;
      end
      ptzfe_pkg::OP_AUTOPAN_STOP: begin
        c[0] = ptzfe_pkg::ExtCmd; c[1] = ptzfe_pkg::AutopanCmd; c[2] = 8'h00; c[3] = n14;
      end
      ptzfe_pkg::OP_TOUR_RUN: begin
        c[0] = ptzfe_pkg::ExtCmd; c[1] = ptzfe_pkg::TourCmd; c[2] = 8'h01; c[3] = n14;
      end
      ptzfe_pkg::OP_TOUR_STOP: begin
        c[0] = ptzfe_pkg::ExtCmd; c[1] = ptzfe_pkg::TourCmd; c[2] = 8'h00; c[3] = n14;
      end
      ptzfe_pkg::OP_MENU_ON: begin
        c[0] = ptzfe_pkg::ExtCmd; c[1] = ptzfe_pkg::MenuCmd; c[2] = 8'h01;
      end
      ptzfe_pkg::OP_MENU_OFF: begin
        c[0] = ptzfe_pkg::ExtCmd; c[1] = ptzfe_pkg::MenuCmd; c[2] = 8'h00;
      end
      ptzfe_pkg::OP_RESET: begin
        c[0] = ptzfe_pkg::ExtCmd; c[1] = ptzfe_pkg::ResetCmd; c[2] = 8'hff;
      end
      ptzfe_pkg::OP_ZOOM_SPEED: begin
        c[1] = ptzfe_pkg::ZoomSpdCmd; c[2] = {n14[4:0], 3'b000};
        c[3] = 8'h00; c[4] = 8'h00;
      end
      default: ; // noop and unused codes keep the noop bytes
    endcase
  end

  // low byte of 0xffff minus the seven bytes is the inverted low byte of their sum
  assign sum = sender_address + target_address + c[0] + c[1] + c[2] + c[3] + c[4];

  always_comb begin
    frame[0] = ptzfe_pkg::StartByte;
    frame[1] = sender_address;
    frame[2] = target_address;
    frame[3] = c[0];
    frame[4] = c[1];
    frame[5] = c[2];
    frame[6] = c[3];
    frame[7] = c[4];
    frame[8] = ~sum;
  end

endmodule

`default_nettype wire

/* design/ptz_command_frame_encoder_top.sv */
// ----------------------------------------------------------------------------
// ptz_command_frame_encoder_top
// Pan-tilt-zoom serial command frame encoder, one frame byte per cycle.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Its whole nine-byte
// frame is built in the cycle of the transfer and loaded into a byte shift
// register; from the next cycle on one byte leaves per cycle with strobe high,
// last marking the checksum byte. A command therefore holds the single
// byte-wide result port for its whole frame. busy drops during the checksum
// byte, so a new command can follow with no gap between frames. The receiver
// cannot stall: every strobed byte must be taken in its cycle.
`timescale 1ns / 1ps
`default_nettype none

module ptz_command_frame_encoder_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [4:0] op,
  input  wire logic [7:0] sender_address,
  input  wire logic [7:0] target_address,
  input  wire logic [7:0] pan_speed,
  input  wire logic [7:0] tilt_speed,
  input  wire logic [7:0] number,
  output logic            strobe,
  output logic [7:0]      frame_byte,
  output logic            last
);

  localparam logic [3:0] LastIdx = 4'(ptzfe_pkg::FrameBytes - 1);

  ptzfe_pkg::frame_t frame;
  ptzfe_pkg::frame_t shreg;
  logic              sending;
  logic [3:0]        idx;
  logic              accept;

  ptzfe_cmd_encode u_encode (
    .op             (op),
    .sender_address (sender_address),
    .target_address (target_address),
    .pan_speed      (pan_speed),
    .tilt_speed     (tilt_speed),
    .number         (number),
    .frame          (frame)
  );

  assign busy   = sending && (idx != LastIdx);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      sending <= 1'b0;
      idx     <= '0;
    end else if (accept) begin
      sending <= 1'b1;
      idx     <= '0;
    end else if (sending) begin
      if (idx == LastIdx) begin
        sending <= 1'b0;
      end else begin
        idx <= idx + 4'd1;
      end
    end
  end

  // byte 0 sits at the bottom and goes out first
  always_ff @(posedge clk) begin
    if (accept) begin
      shreg <= frame;
    end else if (sending) begin
      shreg <= ptzfe_pkg::frame_t'(shreg >> 8);
    end
  end

  assign strobe     = sending;
  assign frame_byte = shreg[0];
  assign last       = sending && (idx == LastIdx);

`ifndef ASSERT_OFF
  a_busy_in_frame : assert property (@(posedge clk) disable iff (rst)
    busy |-> strobe && !last)
    else $error("busy outside a frame or on its checksum byte");

  a_frame_starts : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> strobe && !last && (frame_byte == ptzfe_pkg::StartByte))
    else $error("frame did not open with the start byte");

  a_frame_runs : assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> strobe)
    else $error("frame broke off before its checksum byte");

  a_frame_ends : assert property (@(posedge clk) disable iff (rst)
    (last && !start) |=> !strobe)
    else $error("byte sent after the checksum with no new transfer");
`endif

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pan-tilt-zoom command frame encoder: commands
// go in with random gaps, each one is turned into its nine expected frame
// bytes, and every strobed byte is checked in order against them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ptzfe_pkg::*;

  class frame_scoreboard;
    logic [7:0] frame_bytes_due[$];
    bit         last_flags_due[$];
    int         mismatches;

    function logic [7:0] clamp(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function frame_t encode_command(logic [4:0] code, logic [7:0] snd, logic [7:0] tgt,
                                    logic [7:0] pan, logic [7:0] tilt,
                                    logic [7:0] num);
      frame_t           f;
      logic [7:0]       cmd [CmdBytes];
      logic [7:0]       ps;
      logic [7:0]       ts;
      logic [7:0]       pat;
      logic [7:0]       n14;
      logic [7:0]       pre;
      logic [15:0]      sum;
      ps  = clamp(pan, 8'd0, SpeedMax);
      ts  = clamp(tilt, 8'd0, SpeedMax);
      pat = clamp(num, 8'd1, 8'd3);
      n14 = clamp(num, 8'd1, 8'd4);
      pre = num - 8'd1;
      // noop frame unless the opcode says otherwise
      cmd[0] = 8'h01; cmd[1] = 8'h00; cmd[2] = 8'h00; cmd[3] = 8'hff; cmd[4] = 8'hff;
      case (op_t'(code))
        OP_LEFT: begin
          cmd[2] = 8'h01; cmd[3] = ps;
        end
        OP_RIGHT: begin
          cmd[2] = 8'h02; cmd[3] = ps;
        end
        OP_UP: begin
          cmd[2] = 8'h04; cmd[4] = ps;
        end
        OP_DOWN: begin
          cmd[2] = 8'h08; cmd[4] = ps;
        end
        OP_UP_LEFT: begin
          cmd[2] = 8'h05; cmd[3] = ps; cmd[4] = ts;
        end
        OP_DOWN_LEFT: begin
          cmd[2] = 8'h09; cmd[3] = ps; cmd[4] = ts;
        end
        OP_UP_RIGHT: begin
          cmd[2] = 8'h06; cmd[3] = ps; cmd[4] = ts;
        end
        OP_DOWN_RIGHT: begin
          cmd[2] = 8'h0a; cmd[3] = ps; cmd[4] = ts;
        end
        OP_AUTOSCAN, OP_PATTERN_START: begin
          for (int k = 0; k < CmdBytes; k++) cmd[k] = 8'hff;
        end
        OP_FOCUS_NEAR: cmd[1] = 8'h02;
        OP_FOCUS_FAR:  cmd[1] = 8'h01;
        OP_IRIS_OPEN:  cmd[1] = 8'h08;
        OP_IRIS_CLOSE: cmd[1] = 8'h10;
        OP_ZOOM_TELE:  cmd[1] = 8'h20;
        OP_ZOOM_WIDE:  cmd[1] = 8'h40;
        OP_PRESET_SET: begin
          cmd[0] = ExtCmd; cmd[1] = PresetSet; cmd[2] = pre;
        end
        OP_PRESET_GOTO: begin
          cmd[0] = ExtCmd; cmd[1] = PresetGoto; cmd[2] = pre;
        end
        OP_PRESET_CLEAR: begin
          cmd[0] = ExtCmd; cmd[1] = PresetClr; cmd[2] = pre;
        end
        OP_PATTERN_RUN: begin
          cmd[0] = ExtCmd; cmd[1] = PatternCmd; cmd[2] = pat; cmd[3] = 8'h01;
        end
        OP_PATTERN_STOP: begin
          cmd[0] = ExtCmd; cmd[1] = PatternCmd; cmd[2] = pat; cmd[3] = 8'h00;
        end
        OP_AUTOPAN_START: begin
          cmd[0] = ExtCmd; cmd[1] = AutopanCmd; cmd[2] = 8'h01; cmd[3] = n14;
        end
        OP_AUTOPAN_STOP: begin
          cmd[0] = ExtCmd; cmd[1] = AutopanCmd; cmd[2] = 8'h00; cmd[3] = n14;
        end
        OP_TOUR_RUN: begin
          cmd[0] = ExtCmd; cmd[1] = TourCmd; cmd[2] = 8'h01; cmd[3] = n14;
        end
        OP_TOUR_STOP: begin
          cmd[0] = ExtCmd; cmd[1] = TourCmd; cmd[2] = 8'h00; cmd[3] = n14;
        end
        OP_MENU_ON: begin
          cmd[0] = ExtCmd; cmd[1] = MenuCmd; cmd[2] = 8'h01;
        end
        OP_MENU_OFF: begin
          cmd[0] = ExtCmd; cmd[1] = MenuCmd; cmd[2] = 8'h00;
        end
        OP_RESET: begin
          cmd[0] = ExtCmd; cmd[1] = ResetCmd; cmd[2] = 8'hff;
        end
        OP_ZOOM_SPEED: begin
          cmd[1] = ZoomSpdCmd; cmd[2] = {n14[4:0], 3'b000}; cmd[3] = 8'h00; cmd[4] = 8'h00;
        end
        default: ;
      endcase
      f[0] = StartByte;
      f[1] = snd;
      f[2] = tgt;
      for (int k = 0; k < CmdBytes; k++) f[3 + k] = cmd[k];
      sum = 16'hffff;
      for (int k = 1; k < 8; k++) sum = sum - {8'h00, f[k]};
      f[8] = sum[7:0];
      return f;
    endfunction

    function void note_command(logic [4:0] code, logic [7:0] snd, logic [7:0] tgt,
                               logic [7:0] pan, logic [7:0] tilt, logic [7:0] num);
      frame_t f;
      f = encode_command(code, snd, tgt, pan, tilt, num);
      for (int k = 0; k < FrameBytes; k++) begin
        frame_bytes_due.push_back(f[k]);
        last_flags_due.push_back(k == FrameBytes - 1);
      end
    endfunction

    function int pending();
      return frame_bytes_due.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_byte(logic [7:0] data, logic tail);
      logic [7:0] want_byte;
      bit         want_last;
      if (frame_bytes_due.size() == 0) begin
        report($sformatf("byte %02h strobed with no frame pending", data));
      end else begin
        want_byte = frame_bytes_due.pop_front();
        want_last = last_flags_due.pop_front();
        if (data !== want_byte)
          report($sformatf("frame_byte %02h, expected %02h", data, want_byte));
        if (tail !== want_last)
          report($sformatf("last %b, expected %b", tail, want_last));
      end
    endtask
  endclass

  logic       clk;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [4:0] op = '0;
  logic [7:0] sender_address = '0;
  logic [7:0] target_address = '0;
  logic [7:0] pan_speed = '0;
  logic [7:0] tilt_speed = '0;
  logic [7:0] number = '0;
  logic       strobe;
  logic [7:0] frame_byte;
  logic       last;

  frame_scoreboard sb;

  ptz_command_frame_encoder_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .sender_address (sender_address),
    .target_address (target_address),
    .pan_speed      (pan_speed),
    .tilt_speed     (tilt_speed),
    .number         (number),
    .strobe         (strobe),
    .frame_byte     (frame_byte),
    .last           (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("** ptz_command_frame_encoder_top: FAILED **");
    $finish;
  end

  // values sampled here are the ones from before the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) sb.check_byte(frame_byte, last);
      if (start && !busy)
        sb.note_command(op, sender_address, target_address, pan_speed, tilt_speed, number);
    end
  end

  // speeds and numbers cluster around the clamp limits as well as the byte ends
  function logic [7:0] pick_arg();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 255));
      1:       return 8'($urandom_range(0, 8));
      2:       return 8'($urandom_range(60, 68));
      default: return 8'($urandom_range(247, 255));
    endcase
  endfunction

  // start stays high straight through back-to-back transfers
  task send_command(logic [4:0] code, logic [7:0] snd, logic [7:0] tgt,
                    logic [7:0] pan, logic [7:0] tilt, logic [7:0] num, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op             <= code;
    sender_address <= snd;
    target_address <= tgt;
    pan_speed      <= pan;
    tilt_speed     <= tilt;
    number         <= num;
    start          <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    logic [7:0] speeds [4];
    logic [7:0] nums [6];
    int         burst;
    int         gap;
    speeds = '{8'd0, 8'd64, 8'd65, 8'd255};
    nums   = '{8'd1, 8'd3, 8'd255, 8'd4, 8'd0, 8'd5};
    burst  = 0;
    sb = new();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // every opcode incl. the two unused ones, fields at their limits
    for (int c = 0; c < 32; c++)
      send_command(5'(c), (c % 2) ? 8'hff : 8'h00, (c % 2) ? 8'h00 : 8'hff,
                   speeds[c % 4], speeds[(c + 1) % 4], nums[c % 6], c % 3);

    for (int n = 0; n < 248; n++) begin
      if (burst == 0 && $urandom_range(0, 19) == 0) burst = $urandom_range(5, 15);
      if (burst > 0) begin
        burst--;
        gap = 0;
      end else begin
        gap = $urandom_range(0, 11);
      end
      send_command(5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), pick_arg(), pick_arg(), pick_arg(), gap);
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    // a stray strobe after the final frame would show up here
    repeat (12) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("** ptz_command_frame_encoder_top: PASSED **");
    end else begin
      $display("** ptz_command_frame_encoder_top: FAILED **");
    end
    $finish;
  end

endmodule
